[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the charge power meter.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (expr)) \
        else $error(msg);

// Condition that must hold in the same cycle as a trigger.
`define ASSERT_IMPLY(label, clk, rst_n, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (expr)) \
        else $error(msg);

`endif

[rtl/cpem_pkg.sv]
// Package for the charge power meter: field widths, beat layout and constants.
// No dependencies.
package cpem_pkg;

    // field widths
    localparam int POWER_W  = 20;   // non-negative power sample
    localparam int PIN_W    = 21;   // signed power field
    localparam int TIME_W   = 32;
    localparam int SOC_W    = 15;
    localparam int CAP_W    = 18;
    localparam int AVG_W    = 21;
    localparam int ENERGY_W = 56;
    localparam int TGT_W    = 8;
    localparam int ETA_W    = 17;

    // beat layout
    localparam int IN_W       = 88;
    localparam int OUT_W      = 104;
    localparam int IN_PWR_LSB = 0;
    localparam int IN_TIM_LSB = 21;
    localparam int IN_SOD_LSB = 53;
    localparam int IN_SOR_LSB = 68;
    localparam int OUT_AVG_LSB = 0;
    localparam int OUT_ENG_LSB = 21;
    localparam int OUT_TGT_LSB = 77;
    localparam int OUT_ETA_LSB = 85;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CAP_IDX = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = 18'd131000;

    // shared multiplier operand widths
    localparam int MUL_A_W = 38;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // shared restoring divider: quotient bits per run
    localparam int DIV_STEPS = 20;
    localparam int DIV_CNT_W = 5;
    localparam int SAT_SHIFT = 17;  // quotient at or above 2**17 saturates at once

    // time-to-target scaling
    localparam int D60_W       = 20;   // (goal - soc) * 60 fits here
    localparam int SCALE_DEN_W = 14;   // 10000 fits here
    localparam logic [MUL_B_W-1:0] MIN_SCALE  = 20'd60;
    localparam logic [MUL_B_W-1:0] SOC_SCALE  = 20'd10000;
    localparam logic [SOC_W-2:0]   SOC_KNEE   = 14'd8000;
    localparam logic [SOC_W-2:0]   SOC_FULL   = 14'd10000;
    localparam logic [TGT_W-1:0]   TARGET_LOW  = 8'd80;
    localparam logic [TGT_W-1:0]   TARGET_HIGH = 8'd100;
    localparam logic [ETA_W-1:0]   ETA_MAX     = 17'd65535;

endpackage

[rtl/charge_power_energy_eta_meter_unit.sv]
// Charge power meter top level: averaging ring, energy integrator, time-to-target.
// Depends on cpem_pkg and assert_macros.svh.
// Path from input beat to result beat: the worst path adds the energy step
//   and runs the shared 20-step restoring divider twice (window average, then time to target).
// Input beats are taken one at a time, only in idle; a result waiting on m_tready holds the sequencer.
// Reset: synchronous on aresetn low; ring fill and slot, sums, session and energy clear, capacity = 131000.
`include "assert_macros.svh"

module charge_power_energy_eta_meter_unit #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input beats
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // power_w[20:0], time_ms[52:21], soc_display[67:53], soc_raw[82:68], zeros above
    input  logic [cpem_pkg::IN_W-1:0]        s_tdata,
    // result beats
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // avg_power_w[20:0], session_energy_wms[76:21], target_pct[84:77],
    // eta_minutes[101:85], zeros above
    output logic [cpem_pkg::OUT_W-1:0]       m_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cpem_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cpem_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cpem_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    // derived widths
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = cpem_pkg::POWER_W + SLOT_W;
    localparam int DEN_W  = cpem_pkg::SCALE_DEN_W + SUM_W;
    localparam int NUM_W  = cpem_pkg::D60_W + cpem_pkg::CAP_W + FILL_W;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [cpem_pkg::DIV_CNT_W-1:0] DIV_LAST =
        cpem_pkg::DIV_CNT_W'(cpem_pkg::DIV_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_UPDATE, ST_EMUL, ST_EACC, ST_AVG_SET, ST_AVG_DIV, ST_ETA_SET,
        ST_MUL_CAP, ST_MUL_FILL, ST_MUL_DEN, ST_ETA_CHK, ST_ETA_DIV, ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // latched sample
    logic [cpem_pkg::POWER_W-1:0] pw_reg, pw_next;
    logic [cpem_pkg::TIME_W-1:0]  now_reg, now_next;
    logic [cpem_pkg::SOC_W-1:0]   soc_reg, soc_next;

    // meter state
    logic [cpem_pkg::CAP_W-1:0]    cap_reg, cap_next;
    logic [SLOT_W-1:0]             slot_reg, slot_next;
    logic [FILL_W-1:0]             fill_reg, fill_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [cpem_pkg::TIME_W-1:0]   last_reg, last_next;
    logic                          active_reg, active_next;
    logic [cpem_pkg::ENERGY_W-1:0] energy_reg, energy_next;

    // ring memory, read port registered
    logic [cpem_pkg::POWER_W-1:0] ring_mem [WINDOW_DEPTH];
    logic [cpem_pkg::POWER_W-1:0] rd_reg;
    logic                         ring_we;

    // shared arithmetic
    logic [cpem_pkg::MUL_P_W-1:0]   prod_reg, prod_next;
    logic [NUM_W-1:0]               num_reg, num_next;
    logic [DEN_W-1:0]               den_reg, den_next;
    logic [DEN_W-1:0]               rem_reg, rem_next;
    logic [cpem_pkg::DIV_STEPS-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0]               dvs_reg, dvs_next;
    logic [cpem_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // result fields
    logic [cpem_pkg::AVG_W-1:0] avg_reg, avg_next;
    logic [cpem_pkg::TGT_W-1:0] tgt_reg, tgt_next;
    logic [cpem_pkg::ETA_W-1:0] eta_reg, eta_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [cpem_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    // combinational helpers
    logic [cpem_pkg::MUL_A_W-1:0] mul_a;
    logic [cpem_pkg::MUL_B_W-1:0] mul_b;
    logic [cpem_pkg::MUL_P_W-1:0] mul_p;
    logic [DEN_W:0]               div_shift, div_diff;
    logic                         div_ge;
    logic [DEN_W-1:0]             div_rem;
    logic [cpem_pkg::DIV_STEPS-1:0] div_quo;
    logic [cpem_pkg::POWER_W-1:0] w_now, w_old;
    logic [cpem_pkg::TIME_W-1:0]  elapsed;
    logic [cpem_pkg::SOC_W-2:0]   soc_mag, goal;
    logic [cpem_pkg::TGT_W-1:0]   tgt_c;
    logic                         soc_unknown;
    logic [cpem_pkg::ENERGY_W:0]  e_sum;
    logic                         cfg_wr;
    logic [cpem_pkg::SOC_W-1:0]   in_sod, in_sor;

    // ------------------------------------------------------------------
    // APB: one register, write in the access phase
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == cpem_pkg::REG_CAP_IDX);
    assign prdata = (paddr[2] == cpem_pkg::REG_CAP_IDX) ?
                    cpem_pkg::APB_DATA_W'(cap_reg) : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_sod = s_tdata[cpem_pkg::IN_SOD_LSB +: cpem_pkg::SOC_W];
    assign in_sor = s_tdata[cpem_pkg::IN_SOR_LSB +: cpem_pkg::SOC_W];

    // power of the latched sample; only used when it is not negative
    assign w_now = pw_reg;
    // an entry only holds a stored sample once the ring has wrapped
    assign w_old = (fill_reg == FILL_MAX) ? rd_reg : '0;

    // elapsed time wraps modulo 2**32
    assign elapsed = now_reg - last_reg;

    // charge target from the chosen SOC
    assign soc_unknown = soc_reg[cpem_pkg::SOC_W-1];
    assign soc_mag     = soc_reg[cpem_pkg::SOC_W-2:0];
    assign goal  = (soc_mag < cpem_pkg::SOC_KNEE) ? cpem_pkg::SOC_KNEE : cpem_pkg::SOC_FULL;
    assign tgt_c = (soc_mag < cpem_pkg::SOC_KNEE) ? cpem_pkg::TARGET_LOW
                                                  : cpem_pkg::TARGET_HIGH;

    // ------------------------------------------------------------------
    // Shared multiplier: operands chosen by the sequencer step
    // ------------------------------------------------------------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_EMUL: begin
                mul_a = cpem_pkg::MUL_A_W'(elapsed);
                mul_b = cpem_pkg::MUL_B_W'(w_now);
            end
            ST_ETA_SET: begin
                mul_a = cpem_pkg::MUL_A_W'(goal - soc_mag);
                mul_b = cpem_pkg::MIN_SCALE;
            end
            ST_MUL_CAP: begin
                mul_a = prod_reg[cpem_pkg::MUL_A_W-1:0];
                mul_b = cpem_pkg::MUL_B_W'(cap_reg);
            end
            ST_MUL_FILL: begin
                mul_a = prod_reg[cpem_pkg::MUL_A_W-1:0];
                mul_b = cpem_pkg::MUL_B_W'(fill_reg);
            end
            ST_MUL_DEN: begin
                mul_a = cpem_pkg::MUL_A_W'(sum_reg);
                mul_b = cpem_pkg::SOC_SCALE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = cpem_pkg::MUL_P_W'(mul_a) * cpem_pkg::MUL_P_W'(mul_b);

    // ------------------------------------------------------------------
    // Shared restoring divider step: one quotient bit a cycle
    // ------------------------------------------------------------------
    assign div_shift = {rem_reg, quo_reg[cpem_pkg::DIV_STEPS-1]};
    assign div_ge    = (div_shift >= {1'b0, dvs_reg});
    assign div_diff  = div_shift - {1'b0, dvs_reg};
    assign div_rem   = div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
    assign div_quo   = {quo_reg[cpem_pkg::DIV_STEPS-2:0], div_ge};

    // saturating energy add
    assign e_sum = {1'b0, energy_reg} + (cpem_pkg::ENERGY_W + 1)'(prod_reg);

    // ------------------------------------------------------------------
    // Sequencer next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        pw_next       = pw_reg;
        now_next      = now_reg;
        soc_next      = soc_reg;
        cap_next      = cfg_wr ? pwdata[cpem_pkg::CAP_W-1:0] : cap_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        sum_next      = sum_reg;
        last_next     = last_reg;
        active_next   = active_reg;
        energy_next   = energy_reg;
        prod_next     = prod_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvs_next      = dvs_reg;
        cnt_next      = cnt_reg;
        avg_next      = avg_reg;
        tgt_next      = tgt_reg;
        eta_next      = eta_reg;
        ring_we       = 1'b0;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pw_next  = s_tdata[cpem_pkg::IN_PWR_LSB +: cpem_pkg::POWER_W];
                    now_next = s_tdata[cpem_pkg::IN_TIM_LSB +: cpem_pkg::TIME_W];
                    // prefer the displayed SOC, fall back to the raw one
                    soc_next = in_sod[cpem_pkg::SOC_W-1] ? in_sor : in_sod;
                    // a negative sample leaves the meter state alone
                    state_next = s_tdata[cpem_pkg::IN_PWR_LSB + cpem_pkg::PIN_W - 1] ?
                                 ST_AVG_SET : ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                ring_we   = 1'b1;
                sum_next  = sum_reg - SUM_W'(w_old) + SUM_W'(w_now);
                slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                if (fill_reg != FILL_MAX) begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_AVG_SET;
                if (w_now != '0) begin
                    if (!active_reg) begin
                        // fresh session: clear the total and start timing
                        energy_next = '0;
                        active_next = 1'b1;
                        last_next   = now_reg;
                    end else begin
                        state_next = ST_EMUL;
                    end
                end else begin
                    active_next = 1'b0;
                end
            end
            ST_EMUL: begin
                prod_next  = mul_p;
                state_next = ST_EACC;
            end
            ST_EACC: begin
                energy_next = e_sum[cpem_pkg::ENERGY_W] ? '1
                                                         : e_sum[cpem_pkg::ENERGY_W-1:0];
                last_next   = now_reg;
                state_next  = ST_AVG_SET;
            end
            ST_AVG_SET: begin
                if (fill_reg == '0) begin
                    avg_next   = '1;
                    state_next = ST_ETA_SET;
                end else begin
                    rem_next   = DEN_W'(sum_reg >> cpem_pkg::DIV_STEPS);
                    quo_next   = sum_reg[cpem_pkg::DIV_STEPS-1:0];
                    dvs_next   = DEN_W'(fill_reg);
                    cnt_next   = '0;
                    state_next = ST_AVG_DIV;
                end
            end
            ST_AVG_DIV: begin
                rem_next = div_rem;
                quo_next = div_quo;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    avg_next   = cpem_pkg::AVG_W'(div_quo);
                    state_next = ST_ETA_SET;
                end
            end
            ST_ETA_SET: begin
                tgt_next = soc_unknown ? '1 : tgt_c;
                if (soc_unknown || (fill_reg == '0) || (sum_reg == '0)) begin
                    eta_next   = '1;
                    state_next = ST_DONE;
                end else if (soc_mag >= goal) begin
                    eta_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    prod_next  = mul_p;
                    state_next = ST_MUL_CAP;
                end
            end
            ST_MUL_CAP: begin
                prod_next  = mul_p;
                state_next = ST_MUL_FILL;
            end
            ST_MUL_FILL: begin
                num_next   = mul_p[NUM_W-1:0];
                state_next = ST_MUL_DEN;
            end
            ST_MUL_DEN: begin
                den_next   = mul_p[DEN_W-1:0];
                state_next = ST_ETA_CHK;
            end
            ST_ETA_CHK: begin
                // quotient of 2**17 or more saturates without a division run
                if (DEN_W'(num_reg >> cpem_pkg::SAT_SHIFT) >= den_reg) begin
                    eta_next   = cpem_pkg::ETA_MAX;
                    state_next = ST_DONE;
                end else begin
                    rem_next   = DEN_W'(num_reg >> cpem_pkg::DIV_STEPS);
                    quo_next   = num_reg[cpem_pkg::DIV_STEPS-1:0];
                    dvs_next   = den_reg;
                    cnt_next   = '0;
                    state_next = ST_ETA_DIV;
                end
            end
            ST_ETA_DIV: begin
                rem_next = div_rem;
                quo_next = div_quo;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    eta_next = (div_quo[cpem_pkg::DIV_STEPS-1:cpem_pkg::ETA_W-1] != '0) ?
                               cpem_pkg::ETA_MAX : cpem_pkg::ETA_W'(div_quo);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // park the result once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(cpem_pkg::OUT_W - cpem_pkg::OUT_ETA_LSB
                                       - cpem_pkg::ETA_W){1'b0}},
                                     eta_reg, tgt_reg, energy_reg, avg_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_reg      <= cpem_pkg::CAP_RESET;
            slot_reg     <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            last_reg     <= '0;
            active_reg   <= 1'b0;
            energy_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            slot_reg     <= slot_next;
            fill_reg     <= fill_next;
            sum_reg      <= sum_next;
            last_reg     <= last_next;
            active_reg   <= active_next;
            energy_reg   <= energy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pw_reg      <= pw_next;
        now_reg     <= now_next;
        soc_reg     <= soc_next;
        prod_reg    <= prod_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
        cnt_reg     <= cnt_next;
        avg_reg     <= avg_next;
        tgt_reg     <= tgt_next;
        eta_reg     <= eta_next;
        m_tdata_reg <= m_tdata_next;
    end

    // ring memory: one write and one registered read at the current slot
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[slot_reg] <= w_now;
        end
        rd_reg <= ring_mem[slot_reg];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_reg <= FILL_MAX,
        "fill count beyond window depth")
    `ASSERT_IMPLY(a_empty_sum, aclk, aresetn, fill_reg == '0, sum_reg == '0,
        "window sum non-zero with empty ring")
    `ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "second beat taken while the sequencer is busy")
    `ASSERT_IMPLY(a_eta_needs_target, aclk, aresetn,
        m_tvalid_reg && (m_tdata_reg[cpem_pkg::OUT_ETA_LSB +: cpem_pkg::ETA_W] != '1),
        m_tdata_reg[cpem_pkg::OUT_TGT_LSB +: cpem_pkg::TGT_W] != '1,
        "time to target given without a known target")

endmodule
